// File: sv/vfa_pkg.sv
`default_nettype none

package vfa_pkg;

    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
    localparam logic [OP_W-1:0] OP_MULS  = 4'd4;
    localparam logic [OP_W-1:0] OP_DIVS  = 4'd5;
    localparam logic [OP_W-1:0] OP_DOT   = 4'd6;
    localparam logic [OP_W-1:0] OP_CROSS = 4'd7;
    localparam logic [OP_W-1:0] OP_LEN   = 4'd8;
    localparam logic [OP_W-1:0] OP_NORM  = 4'd9;
    localparam logic [OP_W-1:0] OP_NFAST = 4'd10;

endpackage

`default_nettype wire

// File: sv/vfa_lane.sv
`default_nettype none

module vfa_lane
    import vfa_pkg::*;
#(
    parameter int WIDTH     = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire  [OP_W-1:0]          i_op,
    input  wire  signed [WIDTH-1:0]  i_a,
    input  wire  signed [WIDTH-1:0]  i_b,
    input  wire  signed [WIDTH-1:0]  i_s,
    input  wire  signed [WIDTH-1:0]  i_c1a,
    input  wire  signed [WIDTH-1:0]  i_c1b,
    input  wire  signed [WIDTH-1:0]  i_c2a,
    input  wire  signed [WIDTH-1:0]  i_c2b,
    output logic signed [2*WIDTH-1:0] o_pab,
    output logic [2*WIDTH-1:0]       o_paa,
    output logic [WIDTH-1:0]         o_res,
    output logic                     o_ovf
);

    localparam int W = WIDTH;
    localparam int P = 2 * WIDTH + 1;

    logic signed [2*W-1:0] w_ea, w_eb, w_es, w_e1a, w_e1b, w_e2a, w_e2b;
    logic signed [2*W-1:0] w_c1, w_c2;
    logic signed [W:0]     w_sa, w_sb;

    logic [OP_W-1:0]       r_op;
    logic signed [W:0]     r_sum, n_sum;
    logic signed [2*W-1:0] r_pab, r_pas, r_paa;
    logic signed [P-1:0]   r_pcr;

    assign w_ea  = {{W{i_a[W-1]}}, i_a};
    assign w_eb  = {{W{i_b[W-1]}}, i_b};
    assign w_es  = {{W{i_s[W-1]}}, i_s};
    assign w_e1a = {{W{i_c1a[W-1]}}, i_c1a};
    assign w_e1b = {{W{i_c1b[W-1]}}, i_c1b};
    assign w_e2a = {{W{i_c2a[W-1]}}, i_c2a};
    assign w_e2b = {{W{i_c2b[W-1]}}, i_c2b};
    assign w_c1  = w_e1a * w_e1b;
    assign w_c2  = w_e2a * w_e2b;
    assign w_sa  = {i_a[W-1], i_a};
    assign w_sb  = {i_b[W-1], i_b};
    assign n_sum = (i_op == OP_SUB) ? (w_sa - w_sb) : (w_sa + w_sb);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op  <= i_op;
            r_sum <= n_sum;
            r_pab <= w_ea * w_eb;
            r_pas <= w_ea * w_es;
            r_paa <= w_ea * w_ea;
            r_pcr <= {w_c1[2*W-1], w_c1} - {w_c2[2*W-1], w_c2};
        end
    end

    logic signed [P-1:0] w_v, w_sc, w_pre, w_bias;
    logic                w_ovf;

    assign w_bias = {{(P-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    always_comb begin
        case (r_op)
            OP_MUL:   w_v = {r_pab[2*W-1], r_pab};
            OP_MULS:  w_v = {r_pas[2*W-1], r_pas};
            OP_CROSS: w_v = r_pcr;
            default:  w_v = '0;
        endcase
        // truncate the magnitude toward zero
        w_sc = $signed(w_v + (w_v[P-1] ? w_bias : '0)) >>> FRAC_BITS;
        if (r_op inside {OP_ADD, OP_SUB}) begin
            w_pre = {{(P-W-1){r_sum[W]}}, r_sum};
        end else begin
            w_pre = w_sc;
        end
        w_ovf = !((&w_pre[P-1:W-1]) || !(|w_pre[P-1:W-1]));
        if (w_ovf) begin
            o_res = w_pre[P-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            o_res = w_pre[W-1:0];
        end
    end

    assign o_ovf = w_ovf;
    assign o_pab = r_pab;
    assign o_paa = r_paa;

endmodule

`default_nettype wire

// File: sv/vfa_sqrt.sv
`default_nettype none

module vfa_sqrt #(
    parameter int WIDTH = 32
) (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  wire  [2*WIDTH-1:0]   i_rad,
    output logic [WIDTH-1:0]     o_root
);

    localparam int W  = WIDTH;
    localparam int RW = WIDTH + 2;

    logic [RW-1:0]  r_rem  [W-1];
    logic [W-1:0]   r_root [W];
    logic [2*W-1:0] r_rad  [W-1];

    // one result bit per stage, two radicand bits brought down each time
    for (genvar k = 0; k < W; k++) begin : g_st
        logic [RW-1:0]  rem_in;
        logic [W-1:0]   root_in;
        logic [2*W-1:0] rad_in;
        logic [RW+1:0]  remsh, trial;
        logic           fit;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        assign remsh = {rem_in, rad_in[2*W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign fit   = (remsh >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {root_in[W-2:0], fit};
            end
        end

        if (k < W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= fit ? RW'(remsh - trial) : remsh[RW-1:0];
                    r_rad[k] <= {rad_in[2*W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[W-1];

endmodule

`default_nettype wire

// File: sv/vfa_div.sv
`default_nettype none

module vfa_div #(
    parameter int WIDTH     = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_en,
    input  wire  [WIDTH+FRAC_BITS-1:0]    i_num,
    input  wire  [WIDTH-1:0]              i_den,
    output logic [WIDTH+FRAC_BITS-1:0]    o_quo
);

    localparam int W  = WIDTH;
    localparam int NW = WIDTH + FRAC_BITS;

    logic [W-1:0]  r_rem [NW-1];
    logic [NW-1:0] r_quo [NW];
    logic [NW-1:0] r_num [NW-1];
    logic [W-1:0]  r_den [NW-1];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < NW; k++) begin : g_st
        logic [W-1:0]  rem_in, den_in;
        logic [NW-1:0] quo_in, num_in;
        logic [W:0]    remsh;
        logic          fit;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign num_in = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign num_in = r_num[k-1];
            assign den_in = r_den[k-1];
        end

        assign remsh = {rem_in, num_in[NW-1]};
        assign fit   = (remsh >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {quo_in[NW-2:0], fit};
            end
        end

        if (k < NW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= fit ? W'(remsh - {1'b0, den_in}) : remsh[W-1:0];
                    r_num[k] <= {num_in[NW-2:0], 1'b0};
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

`default_nettype wire

// File: sv/vec3_fixed_point_alu.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_op, i_ax..i_bz, i_scalar
// result    out        o_out_valid / i_out_ready   o_rx, o_ry, o_rz, o_sval,
//                                                  o_zero_div, o_overflow
//
// One item per cycle, every op, unless a result not taken stalls the pipeline. The
// path from the input transfer to o_out_valid runs through the square-root pipeline
// (WIDTH stages) feeding the three lane dividers (WIDTH+FRAC_BITS stages each), plus
// product, merge and output stages.
// Reset clears only the valid bits. A result not taken holds the whole pipeline,
// and o_in_ready is low for exactly those cycles.

module vec3_fixed_point_alu
    import vfa_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WIDTH     = 32
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire  [OP_W-1:0]          i_op,
    input  wire  signed [WIDTH-1:0]  i_ax,
    input  wire  signed [WIDTH-1:0]  i_ay,
    input  wire  signed [WIDTH-1:0]  i_az,
    input  wire  signed [WIDTH-1:0]  i_bx,
    input  wire  signed [WIDTH-1:0]  i_by,
    input  wire  signed [WIDTH-1:0]  i_bz,
    input  wire  signed [WIDTH-1:0]  i_scalar,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic signed [WIDTH-1:0]  o_rx,
    output logic signed [WIDTH-1:0]  o_ry,
    output logic signed [WIDTH-1:0]  o_rz,
    output logic signed [WIDTH-1:0]  o_sval,
    output logic                     o_zero_div,
    output logic                     o_overflow
);

    localparam int W    = WIDTH;
    localparam int NW   = WIDTH + FRAC_BITS;
    localparam int DP   = 2 * WIDTH + 2;
    localparam int LAST = WIDTH + NW;

    localparam logic [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [2:0][W-1:0]   amag;
        logic [2:0]          aneg;
        logic [2:0][W-1:0]   dm;
        logic [2:0]          dneg;
        logic [2:0][W-1:0]   res;
        logic [2:0]          rovf;
        logic [W-1:0]        dot;
        logic                dovf;
        logic [W-1:0]        len;
    } t_sb;

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    logic [W-1:0] w_a [3];
    logic [W-1:0] w_b [3];
    logic [W-1:0] w_smag;

    assign w_a[0] = i_ax;
    assign w_a[1] = i_ay;
    assign w_a[2] = i_az;
    assign w_b[0] = i_bx;
    assign w_b[1] = i_by;
    assign w_b[2] = i_bz;
    assign w_smag = i_scalar[W-1] ? (~i_scalar + {{(W-1){1'b0}}, 1'b1}) : i_scalar;

    // stage 1: magnitudes and divisor choice alongside the lane products
    logic [OP_W-1:0]   r1_op;
    logic [2:0][W-1:0] r1_amag, r1_dm;
    logic [2:0]        r1_aneg, r1_dneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op <= i_op;
            for (int i = 0; i < 3; i++) begin
                r1_amag[i] <= w_a[i][W-1] ? (~w_a[i] + {{(W-1){1'b0}}, 1'b1}) : w_a[i];
                r1_aneg[i] <= w_a[i][W-1];
                if (i_op == OP_DIV) begin
                    r1_dm[i]   <= w_b[i][W-1] ? (~w_b[i] + {{(W-1){1'b0}}, 1'b1}) : w_b[i];
                    r1_dneg[i] <= w_b[i][W-1];
                end else begin
                    r1_dm[i]   <= w_smag;
                    r1_dneg[i] <= i_scalar[W-1];
                end
            end
        end
    end

    logic signed [2*W-1:0] w_pab [3];
    logic [2*W-1:0]        w_paa [3];
    logic [W-1:0]          w_res [3];
    logic                  w_rovf [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vfa_lane #(
            .WIDTH     (WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_op  (i_op),
            .i_a   (w_a[i]),
            .i_b   (w_b[i]),
            .i_s   (i_scalar),
            .i_c1a (w_a[(i+1)%3]),
            .i_c1b (w_b[(i+2)%3]),
            .i_c2a (w_a[(i+2)%3]),
            .i_c2b (w_b[(i+1)%3]),
            .o_pab (w_pab[i]),
            .o_paa (w_paa[i]),
            .o_res (w_res[i]),
            .o_ovf (w_rovf[i])
        );
    end

    // merge: dot product and sum of squares
    logic signed [DP-1:0] w_dsum, w_dsc, w_dbias;
    logic                 w_dovf;
    logic [W-1:0]         w_dot;
    logic [2*W-1:0]       n_sq, r_sq;
    t_sb                  n_sb0;

    assign w_dbias = {{(DP-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    assign w_dsum  = {{2{w_pab[0][2*W-1]}}, w_pab[0]} + {{2{w_pab[1][2*W-1]}}, w_pab[1]}
                   + {{2{w_pab[2][2*W-1]}}, w_pab[2]};
    assign w_dsc   = $signed(w_dsum + (w_dsum[DP-1] ? w_dbias : '0)) >>> FRAC_BITS;
    assign w_dovf  = !((&w_dsc[DP-1:W-1]) || !(|w_dsc[DP-1:W-1]));
    assign w_dot   = w_dovf ? (w_dsc[DP-1] ? MINV : MAXV) : w_dsc[W-1:0];
    assign n_sq    = w_paa[0] + w_paa[1] + w_paa[2];

    always_comb begin
        n_sb0      = '0;
        n_sb0.op   = r1_op;
        n_sb0.amag = r1_amag;
        n_sb0.aneg = r1_aneg;
        n_sb0.dm   = r1_dm;
        n_sb0.dneg = r1_dneg;
        for (int i = 0; i < 3; i++) begin
            n_sb0.res[i]  = w_res[i];
            n_sb0.rovf[i] = w_rovf[i];
        end
        n_sb0.dot  = w_dot;
        n_sb0.dovf = w_dovf;
    end

    // sideband delay line alongside the root and divider pipelines
    t_sb          r_sb [LAST+1];
    t_sb          w_sbl;
    logic [W-1:0] w_root;

    always_comb begin
        w_sbl     = r_sb[W];
        w_sbl.len = w_root;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq    <= n_sq;
            r_sb[0] <= n_sb0;
            for (int k = 1; k <= LAST; k++) begin
                if (k == W + 1) begin
                    r_sb[k] <= w_sbl;
                end else begin
                    r_sb[k] <= r_sb[k-1];
                end
            end
        end
    end

    vfa_sqrt #(
        .WIDTH (WIDTH)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_sq),
        .o_root (w_root)
    );

    logic [NW-1:0] w_quo [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        logic [W-1:0] den;
        assign den = (r_sb[W].op == OP_NORM) ? w_root : r_sb[W].dm[i];

        vfa_div #(
            .WIDTH     (WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num ({r_sb[W].amag[i], {FRAC_BITS{1'b0}}}),
            .i_den (den),
            .o_quo (w_quo[i])
        );
    end

    // final merge of lane quotients and carried results
    logic [W-1:0] n_r [3];
    logic [W-1:0] n_sval;
    logic         n_zd, n_ov;

    always_comb begin
        t_sb           s;
        logic          dz, qn, qpo, qno, qo;
        logic [NW-1:0] q;
        logic [W-1:0]  qv;
        s    = r_sb[LAST];
        n_zd = 1'b0;
        n_ov = 1'b0;
        for (int i = 0; i < 3; i++) begin
            q   = w_quo[i];
            dz  = (s.op == OP_NORM) ? (s.len == '0) : (s.dm[i] == '0);
            qn  = s.aneg[i] ^ (s.dneg[i] && (s.op != OP_NORM));
            qpo = |q[NW-1:W-1];
            qno = (|q[NW-1:W]) || (q[W-1] && (|q[W-2:0]));
            if (qn) begin
                qv = qno ? MINV : (~q[W-1:0] + {{(W-1){1'b0}}, 1'b1});
                qo = qno;
            end else begin
                qv = qpo ? MAXV : q[W-1:0];
                qo = qpo;
            end
            case (s.op)
                OP_DIV: begin
                    if (dz) begin
                        n_r[i] = s.aneg[i] ? MINV : MAXV;
                        n_zd   = 1'b1;
                        n_ov   = 1'b1;
                    end else begin
                        n_r[i] = qv;
                        n_ov   = n_ov | qo;
                    end
                end
                OP_DIVS, OP_NFAST, OP_NORM: begin
                    if (dz) begin
                        n_r[i] = '0;
                        n_zd   = 1'b1;
                    end else begin
                        n_r[i] = qv;
                        n_ov   = n_ov | qo;
                    end
                end
                default: begin
                    n_r[i] = s.res[i];
                    n_ov   = n_ov | s.rovf[i];
                end
            endcase
        end
        case (s.op)
            OP_DOT: begin
                n_sval = s.dot;
                n_ov   = n_ov | s.dovf;
            end
            OP_LEN: begin
                n_sval = s.len[W-1] ? MAXV : s.len;
                n_ov   = n_ov | s.len[W-1];
            end
            default: n_sval = '0;
        endcase
    end

    // valid bits: stage 1, sideband stages, then the output register
    logic [LAST+1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_v         <= {r_v[LAST:0], i_in_valid};
            o_out_valid <= r_v[LAST+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_rx       <= n_r[0];
            o_ry       <= n_r[1];
            o_rz       <= n_r[2];
            o_sval     <= n_sval;
            o_zero_div <= n_zd;
            o_overflow <= n_ov;
        end
    end

endmodule

`default_nettype wire
